FILE: hdl/rlcf_pkg.sv
// rlcf_pkg: widths, codes, constants and lane structs of the rgb linear color fader
// used by every file of the block, depends on nothing
package rlcf_pkg;

    localparam int LVL_W     = 8;
    localparam int DELTA_W   = LVL_W + 1;
    localparam int STEPS_W   = 11;
    localparam int TICKS_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int NUM_LANES = 3;
    localparam int PROD_W    = DELTA_W + STEPS_W;
    localparam int CNT_W     = $clog2(PROD_W);

    localparam logic [CFG_IDX_W-1:0] REG_STEPS      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS = 1'b1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 11'd256;
    localparam logic [STEPS_W-1:0] MAX_STEPS   = 11'd1024;
    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd10;

    typedef struct packed {
        logic               start;
        logic [LVL_W-1:0]   from_lvl;
        logic [DELTA_W-1:0] delta;
        logic [STEPS_W-1:0] idx;
        logic [STEPS_W-1:0] div;
    } lane_req_t;

    typedef struct packed {
        logic             done;
        logic [LVL_W-1:0] level;
    } lane_rsp_t;

endpackage

FILE: hdl/rlcf_if.sv
// rlcf_if: valid/ready channel interfaces for fader items and results
// depends on rlcf_pkg
interface rlcf_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [rlcf_pkg::LVL_W-1:0] from_red;
    logic [rlcf_pkg::LVL_W-1:0] from_green;
    logic [rlcf_pkg::LVL_W-1:0] from_blue;
    logic [rlcf_pkg::LVL_W-1:0] to_red;
    logic [rlcf_pkg::LVL_W-1:0] to_green;
    logic [rlcf_pkg::LVL_W-1:0] to_blue;

    modport source (output valid, cmd, from_red, from_green, from_blue,
                    to_red, to_green, to_blue, input ready);
    modport sink (input valid, cmd, from_red, from_green, from_blue,
                  to_red, to_green, to_blue, output ready);
endinterface

interface rlcf_out_if;
    logic                      valid;
    logic                      ready;
    logic [rlcf_pkg::LVL_W-1:0] red_level;
    logic [rlcf_pkg::LVL_W-1:0] green_level;
    logic [rlcf_pkg::LVL_W-1:0] blue_level;
    logic                      busy_res;
    logic                      finished;

    modport source (output valid, red_level, green_level, blue_level, busy_res, finished,
                    input ready);
    modport sink (input valid, red_level, green_level, blue_level, busy_res, finished,
                  output ready);
endinterface

FILE: hdl/rlcf_lane.sv
// rlcf_lane: one color channel, level = from + trunc(idx * delta / div)
// registered multiply then restoring divide one quotient bit per cycle; depends on rlcf_pkg
module rlcf_lane
(
    input  logic                clk,
    input  logic                rst_n,
    input  rlcf_pkg::lane_req_t req,
    output rlcf_pkg::lane_rsp_t rsp
);

    typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_DIV, PH_FIX} phase_t;

    localparam logic [rlcf_pkg::CNT_W-1:0] LAST_CNT = rlcf_pkg::CNT_W'(rlcf_pkg::PROD_W - 1);

    phase_t                               phase_reg;
    logic [rlcf_pkg::LVL_W-1:0]           from_reg;
    logic                                 neg_reg;
    logic [rlcf_pkg::DELTA_W-1:0]         mag_reg;
    logic [rlcf_pkg::STEPS_W-1:0]         idx_reg;
    logic [rlcf_pkg::STEPS_W-1:0]         div_reg;
    logic [rlcf_pkg::PROD_W-1:0]          prod_reg;
    logic [rlcf_pkg::STEPS_W-1:0]         rem_reg;
    logic [rlcf_pkg::CNT_W-1:0]           cnt_reg;
    logic [rlcf_pkg::LVL_W-1:0]           level_reg;
    logic                                 done_reg;

    logic [rlcf_pkg::STEPS_W:0]           rem_sh;
    logic                                 ge;
    logic [rlcf_pkg::STEPS_W:0]           rem_next;
    logic signed [rlcf_pkg::LVL_W+2:0]    qs;
    logic signed [rlcf_pkg::LVL_W+2:0]    sum;
    logic [rlcf_pkg::LVL_W-1:0]           level_next;

    always_comb
    begin
        rem_sh   = {rem_reg, prod_reg[rlcf_pkg::PROD_W-1]};
        ge       = rem_sh >= {1'b0, div_reg};
        rem_next = ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
        qs       = $signed({2'b00, prod_reg[rlcf_pkg::DELTA_W-1:0]});
        sum      = $signed({3'b000, from_reg}) + (neg_reg ? -qs : qs);
        if (sum < 0)
        begin
            level_next = '0;
        end
        else if (sum > $signed(11'sd255))
        begin
            level_next = '1;
        end
        else
        begin
            level_next = sum[rlcf_pkg::LVL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            from_reg  <= '0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            idx_reg   <= '0;
            div_reg   <= '0;
            prod_reg  <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            level_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (req.start)
                    begin
                        from_reg  <= req.from_lvl;
                        neg_reg   <= req.delta[rlcf_pkg::DELTA_W-1];
                        mag_reg   <= req.delta[rlcf_pkg::DELTA_W-1] ?
                                     (~req.delta + rlcf_pkg::DELTA_W'(1)) : req.delta;
                        idx_reg   <= req.idx;
                        div_reg   <= req.div;
                        phase_reg <= PH_MUL;
                    end
                end
                PH_MUL:
                begin
                    prod_reg  <= rlcf_pkg::PROD_W'(mag_reg) * rlcf_pkg::PROD_W'(idx_reg);
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    phase_reg <= PH_DIV;
                end
                PH_DIV:
                begin
                    prod_reg <= {prod_reg[rlcf_pkg::PROD_W-2:0], ge};
                    rem_reg  <= rem_next[rlcf_pkg::STEPS_W-1:0];
                    cnt_reg  <= cnt_reg + rlcf_pkg::CNT_W'(1);
                    if (cnt_reg == LAST_CNT)
                    begin
                        phase_reg <= PH_FIX;
                    end
                end
                PH_FIX:
                begin
                    level_reg <= level_next;
                    done_reg  <= 1'b1;
                    phase_reg <= PH_IDLE;
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.level = level_reg;

endmodule

FILE: hdl/rgb_linear_color_fader_top.sv
// rgb_linear_color_fader_top: fade control, configuration registers, three channel lanes
// and the merge of their levels into the result register; depends on rlcf_pkg, rlcf_if, rlcf_lane
//
// Usage:
//   in_ch carries items: cmd start (load from/to colors, show the source color) or cmd tick.
//   out_ch returns exactly one result per item: three levels, busy_res and finished.
//   cfg_we / cfg_index / cfg_data write steps (index 0) and step_ticks (index 1);
//   write only while no item is in flight.
// Result timing and flow:
//   a start, an idle tick, a tick inside a step or the tick that ends the fade:
//   result appears in the cycle after the transfer.
//   a tick that moves to a new step: the result waits for the per-lane restoring divider
//   (start pulse, a multiply phase, 20 quotient bits, a fix-up phase and the merge).
//   one item is worked on at a time; the next transfer is taken once the result register
//   is empty or being drained.
// Reset: steps 256, step_ticks 10, fade idle, all levels dark, no result pending.
// Stall: while a result is pending and out_ch.ready is low, the result holds and in_ch.ready stays low.
module rgb_linear_color_fader_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    rlcf_in_if.sink                           in_ch,
    rlcf_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [rlcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rlcf_pkg::CFG_W-1:0]        cfg_data
);

    typedef enum logic {ST_IDLE, ST_CALC} state_t;

    state_t                          state_reg;
    logic [rlcf_pkg::STEPS_W-1:0]    steps_reg;
    logic [rlcf_pkg::TICKS_W-1:0]    ticks_reg;
    logic [rlcf_pkg::LVL_W-1:0]      from_reg  [rlcf_pkg::NUM_LANES];
    logic [rlcf_pkg::DELTA_W-1:0]    delta_reg [rlcf_pkg::NUM_LANES];
    logic [rlcf_pkg::LVL_W-1:0]      level_reg [rlcf_pkg::NUM_LANES];
    logic [rlcf_pkg::STEPS_W-1:0]    step_reg;
    logic [rlcf_pkg::TICKS_W-1:0]    tick_reg;
    logic                            active_reg;
    logic                            start_reg;
    logic                            out_valid_reg;
    logic                            busy_out_reg;
    logic                            fin_out_reg;

    logic [rlcf_pkg::LVL_W-1:0]      in_from [rlcf_pkg::NUM_LANES];
    logic [rlcf_pkg::LVL_W-1:0]      in_to   [rlcf_pkg::NUM_LANES];
    rlcf_pkg::lane_req_t             lane_req [rlcf_pkg::NUM_LANES];
    rlcf_pkg::lane_rsp_t             lane_rsp [rlcf_pkg::NUM_LANES];
    logic [rlcf_pkg::NUM_LANES-1:0]  lane_done;

    logic [rlcf_pkg::STEPS_W-1:0]    eff_steps;
    logic [rlcf_pkg::TICKS_W-1:0]    eff_ticks;
    logic                            in_ready;
    logic                            in_xfer;
    logic                            out_xfer;
    logic [rlcf_pkg::TICKS_W-1:0]    tick_next;
    logic [rlcf_pkg::STEPS_W-1:0]    step_next;
    logic                            step_adv;

    assign in_from[0] = in_ch.from_red;
    assign in_from[1] = in_ch.from_green;
    assign in_from[2] = in_ch.from_blue;
    assign in_to[0]   = in_ch.to_red;
    assign in_to[1]   = in_ch.to_green;
    assign in_to[2]   = in_ch.to_blue;

    always_comb
    begin
        if (steps_reg == '0)
        begin
            eff_steps = rlcf_pkg::STEPS_W'(1);
        end
        else if (steps_reg > rlcf_pkg::MAX_STEPS)
        begin
            eff_steps = rlcf_pkg::MAX_STEPS;
        end
        else
        begin
            eff_steps = steps_reg;
        end
        eff_ticks = (ticks_reg == '0) ? rlcf_pkg::TICKS_W'(1) : ticks_reg;
        tick_next = tick_reg + rlcf_pkg::TICKS_W'(1);
        step_next = step_reg + rlcf_pkg::STEPS_W'(1);
        step_adv  = tick_next >= eff_ticks;
    end

    assign in_ready    = (state_reg == ST_IDLE) && (!out_valid_reg || out_ch.ready);
    assign in_xfer     = in_ch.valid && in_ready;
    assign out_xfer    = out_valid_reg && out_ch.ready;
    assign in_ch.ready = in_ready;

    genvar g;
    generate
        for (g = 0; g < rlcf_pkg::NUM_LANES; g++)
        begin : g_lane
            assign lane_req[g].start    = start_reg;
            assign lane_req[g].from_lvl = from_reg[g];
            assign lane_req[g].delta    = delta_reg[g];
            assign lane_req[g].idx      = step_reg;
            assign lane_req[g].div      = eff_steps;
            assign lane_done[g]         = lane_rsp[g].done;

            rlcf_lane u_lane
            (
                .clk   (clk),
                .rst_n (rst_n),
                .req   (lane_req[g]),
                .rsp   (lane_rsp[g])
            );
        end
    endgenerate

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= rlcf_pkg::STEPS_RESET;
            ticks_reg <= rlcf_pkg::TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rlcf_pkg::REG_STEPS:      steps_reg <= cfg_data[rlcf_pkg::STEPS_W-1:0];
                rlcf_pkg::REG_STEP_TICKS: ticks_reg <= cfg_data[rlcf_pkg::TICKS_W-1:0];
                default:                  ;
            endcase
        end
    end

    // fade control and merge of lane levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            tick_reg      <= '0;
            active_reg    <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            busy_out_reg  <= 1'b0;
            fin_out_reg   <= 1'b0;
            for (int c = 0; c < rlcf_pkg::NUM_LANES; c++)
            begin
                from_reg[c]  <= '0;
                delta_reg[c] <= '0;
                level_reg[c] <= '0;
            end
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (in_ch.cmd == rlcf_pkg::CMD_START)
                        begin
                            for (int c = 0; c < rlcf_pkg::NUM_LANES; c++)
                            begin
                                from_reg[c]  <= in_from[c];
                                level_reg[c] <= in_from[c];
                                delta_reg[c] <= {1'b0, in_to[c]} - {1'b0, in_from[c]};
                            end
                            step_reg      <= '0;
                            tick_reg      <= '0;
                            active_reg    <= 1'b1;
                            out_valid_reg <= 1'b1;
                            busy_out_reg  <= 1'b1;
                            fin_out_reg   <= 1'b0;
                        end
                        else if (active_reg && step_adv)
                        begin
                            tick_reg <= '0;
                            step_reg <= step_next;
                            if (step_next >= eff_steps)
                            begin
                                active_reg    <= 1'b0;
                                out_valid_reg <= 1'b1;
                                busy_out_reg  <= 1'b0;
                                fin_out_reg   <= 1'b1;
                            end
                            else
                            begin
                                start_reg <= 1'b1;
                                state_reg <= ST_CALC;
                            end
                        end
                        else
                        begin
                            if (active_reg)
                            begin
                                tick_reg <= tick_next;
                            end
                            out_valid_reg <= 1'b1;
                            busy_out_reg  <= active_reg;
                            fin_out_reg   <= 1'b0;
                        end
                    end
                end
                ST_CALC:
                begin
                    if (&lane_done)
                    begin
                        for (int c = 0; c < rlcf_pkg::NUM_LANES; c++)
                        begin
                            level_reg[c] <= lane_rsp[c].level;
                        end
                        out_valid_reg <= 1'b1;
                        busy_out_reg  <= 1'b1;
                        fin_out_reg   <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.red_level   = level_reg[0];
    assign out_ch.green_level = level_reg[1];
    assign out_ch.blue_level  = level_reg[2];
    assign out_ch.busy_res    = busy_out_reg;
    assign out_ch.finished    = fin_out_reg;

endmodule
